// File: hw/rtl/ssmix_pkg.sv
// Shared types, constants and arithmetic helpers for the stereo sample mixer.
// No dependencies; the top level refers to everything here by scoped name.
package ssmix_pkg;

  // Field widths of one transaction
  localparam int unsigned SampleW = 16;
  localparam int unsigned VolW    = 11;
  localparam int unsigned ProdW   = SampleW + VolW;   // signed sample times unsigned volume
  localparam int unsigned TotalW  = ProdW + 1;        // accumulator scaled plus product
  localparam int unsigned VolShift = 10;              // volume 1024 is unity gain
  localparam int unsigned QuotW   = TotalW - VolShift;

  // Saturation bound, symmetric
  localparam logic signed [QuotW-1:0] MixMax = QuotW'(32767);
  localparam logic signed [QuotW-1:0] MixMin = -QuotW'(32767);

  // Positions in the clipped field
  localparam int unsigned ClipLeft  = 0;
  localparam int unsigned ClipRight = 1;

  // Mono interpolation weight near:far
  typedef enum logic [1:0] {
    PhaseNear  = 2'd0,  // 1:0
    Phase31    = 2'd1,  // 3:1
    Phase11    = 2'd2,  // 1:1
    Phase13    = 2'd3   // 1:3
  } phase_e;

  typedef struct packed {
    logic signed [SampleW-1:0] mix;
    logic                      clip;
  } mix_res_t;

  // Convert raw sample bits to 16-bit PCM; a byte sample is (s - 128) * 256
  function automatic logic signed [SampleW-1:0] to_pcm16(input logic [SampleW-1:0] raw,
                                                         input logic wide);
    logic signed [SampleW-1:0] pcm;
    if (wide) begin
      pcm = signed'(raw);
    end else begin
      pcm = signed'({~raw[7], raw[6:0], 8'h00});
    end
    return pcm;
  endfunction

  // Weighted mono sample; arithmetic shift rounds toward minus infinity
  function automatic logic signed [SampleW-1:0] interp(input logic signed [SampleW-1:0] near,
                                                       input logic signed [SampleW-1:0] far,
                                                       input phase_e phase);
    logic signed [SampleW+2:0] n_x;
    logic signed [SampleW+2:0] f_x;
    logic signed [SampleW+2:0] sum;
    logic signed [SampleW-1:0] res;
    n_x = (SampleW+3)'(near);
    f_x = (SampleW+3)'(far);
    unique case (phase)
      PhaseNear: begin
        sum = n_x;
        res = near;
      end
      Phase31: begin
        sum = (n_x <<< 1) + n_x + f_x;
        res = SampleW'(sum >>> 2);
      end
      Phase11: begin
        sum = n_x + f_x;
        res = SampleW'(sum >>> 1);
      end
      Phase13: begin
        sum = n_x + (f_x <<< 1) + f_x;
        res = SampleW'(sum >>> 2);
      end
      default: begin
        sum = n_x;
        res = near;
      end
    endcase
    return res;
  endfunction

  // acc + prod / 1024 truncated toward zero, then clamp to the symmetric bound
  function automatic mix_res_t mix_sat(input logic signed [SampleW-1:0] acc,
                                       input logic signed [ProdW-1:0] prod);
    logic signed [TotalW-1:0] total;
    logic signed [QuotW-1:0]  quot;
    mix_res_t                 res;
    total = (TotalW'(acc) <<< VolShift) + TotalW'(prod);
    quot  = QuotW'(total >>> VolShift);
    if (total[TotalW-1] && (|total[VolShift-1:0])) begin
      quot = quot + QuotW'(1);
    end
    if (quot > MixMax) begin
      res.mix  = SampleW'(MixMax);
      res.clip = 1'b1;
    end else if (quot < MixMin) begin
      res.mix  = SampleW'(MixMin);
      res.clip = 1'b1;
    end else begin
      res.mix  = SampleW'(quot);
      res.clip = 1'b0;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/stereo_sample_mix_saturate.sv
// Top level of the stereo sample mixer: input register, mix logic, result register.
// Depends on ssmix_pkg for widths, phase codes and the mix/saturate helpers.
//
// Each transaction mixes one voice sample into a left/right accumulator pair and
// returns the saturated pair with a clip flag per channel. The block is a two-register
// pipeline: the input register feeds one combinational pass (sample conversion, mono
// interpolation, one 16x11 multiply per channel, accumulate, truncate toward zero,
// saturate) into the result register. One transaction is accepted every clock while
// in_stall_o is low; out_valid_o rises once it has passed the input register into the
// result register. in_stall_o rises only when both registers are full and out_stall_i
// holds the result, so output stalls cost no throughput beyond the stall itself.
module stereo_sample_mix_saturate (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [ssmix_pkg::SampleW-1:0]   acc_left_i,
  input  logic signed [ssmix_pkg::SampleW-1:0]   acc_right_i,
  input  logic        [ssmix_pkg::SampleW-1:0]   sample_near_i,
  input  logic        [ssmix_pkg::SampleW-1:0]   sample_far_i,
  input  logic                                   wide_i,
  input  logic                                   stereo_i,
  input  logic        [1:0]                      phase_i,
  input  logic        [ssmix_pkg::VolW-1:0]      vol_left_i,
  input  logic        [ssmix_pkg::VolW-1:0]      vol_right_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [ssmix_pkg::SampleW-1:0]   mix_left_o,
  output logic signed [ssmix_pkg::SampleW-1:0]   mix_right_o,
  output logic        [1:0]                      clipped_o
);

  // Stage A: captured transaction
  logic                                 a_vld_q;
  logic signed [ssmix_pkg::SampleW-1:0] a_acc_l_q, a_acc_r_q;
  logic        [ssmix_pkg::SampleW-1:0] a_near_q, a_far_q;
  logic                                 a_wide_q, a_stereo_q;
  logic        [1:0]                    a_phase_q;
  logic        [ssmix_pkg::VolW-1:0]    a_vol_l_q, a_vol_r_q;

  // Result register
  logic                                 out_vld_q;
  logic signed [ssmix_pkg::SampleW-1:0] out_l_q, out_r_q;
  logic        [1:0]                    out_clip_q;

  logic adv_out, adv_a;
  logic signed [ssmix_pkg::SampleW-1:0] near_pcm, far_pcm, mono, s_l, s_r;
  logic signed [ssmix_pkg::VolW:0]      vol_l_s, vol_r_s;
  logic signed [ssmix_pkg::ProdW-1:0]   prod_l, prod_r;
  ssmix_pkg::mix_res_t                  res_l, res_r;

  // Each register advances when it is empty or its successor advances
  assign adv_out    = !out_vld_q || !out_stall_i;
  assign adv_a      = !a_vld_q || adv_out;
  assign in_stall_o = !adv_a;

  // Convert, interpolate and scale by volume
  always_comb begin
    near_pcm = ssmix_pkg::to_pcm16(a_near_q, a_wide_q);
    far_pcm  = ssmix_pkg::to_pcm16(a_far_q, a_wide_q);
    mono     = ssmix_pkg::interp(near_pcm, far_pcm, ssmix_pkg::phase_e'(a_phase_q));
    if (a_stereo_q) begin
      s_l = near_pcm;
      s_r = far_pcm;
    end else begin
      s_l = mono;
      s_r = mono;
    end
    vol_l_s = signed'({1'b0, a_vol_l_q});
    vol_r_s = signed'({1'b0, a_vol_r_q});
    prod_l  = ssmix_pkg::ProdW'(s_l) * ssmix_pkg::ProdW'(vol_l_s);
    prod_r  = ssmix_pkg::ProdW'(s_r) * ssmix_pkg::ProdW'(vol_r_s);
  end

  // Accumulate, truncate and saturate
  always_comb begin
    res_l = ssmix_pkg::mix_sat(a_acc_l_q, prod_l);
    res_r = ssmix_pkg::mix_sat(a_acc_r_q, prod_r);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_vld_q <= in_valid_i;
      end
      if (adv_out) begin
        out_vld_q <= a_vld_q;
      end
    end
  end

  // Payload registers; load only on a moving transaction
  always_ff @(posedge clk_i) begin
    if (adv_a && in_valid_i) begin
      a_acc_l_q  <= acc_left_i;
      a_acc_r_q  <= acc_right_i;
      a_near_q   <= sample_near_i;
      a_far_q    <= sample_far_i;
      a_wide_q   <= wide_i;
      a_stereo_q <= stereo_i;
      a_phase_q  <= phase_i;
      a_vol_l_q  <= vol_left_i;
      a_vol_r_q  <= vol_right_i;
    end
    if (adv_out && a_vld_q) begin
      out_l_q                          <= res_l.mix;
      out_r_q                          <= res_r.mix;
      out_clip_q[ssmix_pkg::ClipLeft]  <= res_l.clip;
      out_clip_q[ssmix_pkg::ClipRight] <= res_r.clip;
    end
  end

  assign out_valid_o = out_vld_q;
  assign mix_left_o  = out_l_q;
  assign mix_right_o = out_r_q;
  assign clipped_o   = out_clip_q;

`ifndef NO_ASSERTIONS
  // Input backpressure only when every pipeline register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_vld_q && out_vld_q))
    else $error("input stalled with a free pipeline register");

  // A result register that is free or drained never blocks the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && (!out_vld_q || !out_stall_i)) |=> out_vld_q)
    else $error("input register failed to reach the result register");

  // Saturated outputs never reach negative full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mix_left_o != 16'sh8000 && mix_right_o != 16'sh8000))
    else $error("mix output reached negative full scale");

  // A clip flag implies the channel sits on the bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o[ssmix_pkg::ClipLeft]) |->
      (mix_left_o == 16'sd32767 || mix_left_o == -16'sd32767))
    else $error("left clip flag without saturated value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o[ssmix_pkg::ClipRight]) |->
      (mix_right_o == 16'sd32767 || mix_right_o == -16'sd32767))
    else $error("right clip flag without saturated value");
`endif

endmodule
